// File: design/apt_pkg.sv
// apt_pkg: shared types and constants of the affine point transform.
// Used by apt_cell and affine_point_transform; depends on nothing.
package apt_pkg;

    localparam int POS_W = 4;

    localparam logic [1:0] FUNC_MWR = 2'd0;
    localparam logic [1:0] FUNC_OWR = 2'd1;
    localparam logic [1:0] FUNC_PNT = 2'd2;
    localparam logic [1:0] FUNC_VEC = 2'd3;

    localparam logic [1:0] OP_MWR  = 2'd0;
    localparam logic [1:0] OP_OWR  = 2'd1;
    localparam logic [1:0] OP_MAC  = 2'd2;
    localparam logic [1:0] OP_SKIP = 2'd3;

    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // settle count, loaded when the final item leaves the last cell; the drain starts once it has run down
    localparam logic [1:0] SETTLE_CNT = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [1:0]       op;
        logic [2:0]       tgt;
        logic [POS_W-1:0] addr;
        logic [31:0]      value;
        logic             last;
        logic             point;
    } item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } res_t;

endpackage

// File: design/apt_cell.sv
// apt_cell: one output coordinate; holds a matrix column, offset word and accumulator.
// Passes each transaction to its neighbor; results unload through a shift chain.
// Depends on apt_pkg.
module apt_cell
    import apt_pkg::*;
#(
    parameter int DIM = 8,
    parameter int IDX = 0
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  item_t item_in,
    output item_t item_out,
    input  logic  shift,
    input  res_t  res_in,
    output res_t  res_out
);

    localparam int AW = $clog2(DIM);

    logic [31:0]        mem [DIM];
    logic [31:0]        off_reg;
    item_t              pass_reg;
    logic signed [31:0] rd_reg;
    logic signed [31:0] v1_reg;
    logic               mac1_reg, last1_reg, point1_reg;
    logic signed [63:0] prod_reg;
    logic               mac2_reg, last2_reg, point2_reg;
    logic signed [63:0] rnd_reg;
    logic               mac3_reg, last3_reg, point3_reg;
    logic [63:0]        acc_reg;
    logic               last4_reg, point4_reg;
    res_t               res_reg;
    logic [63:0]        sum;
    res_t               fin;
    logic               mine;

    assign mine = (int'(item_in.tgt) == IDX);

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.op == OP_MWR && mine)
        begin
            mem[AW'(item_in.addr)] <= item_in.value;
        end
        if (item_in.valid && item_in.op == OP_OWR && mine)
        begin
            off_reg <= item_in.value;
        end
        if (item_in.valid && item_in.op == OP_MAC)
        begin
            rd_reg <= mem[AW'(item_in.addr)];
        end
        v1_reg     <= item_in.value;
        point1_reg <= item_in.point;
        prod_reg   <= v1_reg * rd_reg;
        point2_reg <= point1_reg;
        rnd_reg    <= (prod_reg + 64'sd32768) >>> 16;
        point3_reg <= point2_reg;
        point4_reg <= point3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg  <= '0;
            mac1_reg  <= 1'b0;
            last1_reg <= 1'b0;
            mac2_reg  <= 1'b0;
            last2_reg <= 1'b0;
            mac3_reg  <= 1'b0;
            last3_reg <= 1'b0;
            last4_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            pass_reg  <= item_in;
            mac1_reg  <= item_in.valid && item_in.op == OP_MAC;
            last1_reg <= item_in.valid && item_in.last;
            mac2_reg  <= mac1_reg;
            last2_reg <= last1_reg;
            mac3_reg  <= mac2_reg;
            last3_reg <= last2_reg;
            last4_reg <= last3_reg;
            if (last4_reg)
            begin
                acc_reg <= '0;
            end
            else if (mac3_reg)
            begin
                acc_reg <= acc_reg + 64'(rnd_reg);
            end
        end
    end

    always_comb
    begin
        sum = acc_reg;
        if (point4_reg)
        begin
            sum = acc_reg + {{32{off_reg[31]}}, off_reg};
        end
        fin.value = sum[31:0];
        fin.sat   = 1'b0;
        if (sum[62:31] != {32{sum[63]}})
        begin
            fin.value = sum[63] ? Q_MIN : Q_MAX;
            fin.sat   = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (last4_reg)
        begin
            res_reg <= fin;
        end
        else if (shift)
        begin
            res_reg <= res_in;
        end
    end

    assign item_out = pass_reg;
    assign res_out  = res_reg;

endmodule

// File: design/affine_point_transform.sv
// affine_point_transform: top level; decodes transactions into a chain of apt_cell.
// Depends on apt_pkg and apt_cell.
//
// Usage:
//   Input channel (item_valid/item_stall) carries func, row, col, value, last.
//   Matrix and offset writes and non-final elements are taken one per cycle.
//   Each transaction enters cell 0 and moves one cell per cycle; cell i keeps
//   matrix column i and adds round(value * M[pos][i]) into its accumulator.
//   A final element (last on a point or vector) closes the run: item_stall
//   rises and stays high until all DIM results have been taken.
//   Results leave on result_valid/result_stall, index 0 first, one per cycle
//   at most; the first is valid once the final element has passed the head
//   register, the cell chain and the four stages inside each cell, and the
//   settle count has run down. While result_stall is high the current result
//   holds and the result chain waits.
//   cfg_write loads depth from cfg_data; write only while idle.
//   Reset clears control state, accumulators and depth; matrix and offset
//   words are undefined until written.
module affine_point_transform
    import apt_pkg::*;
#(
    parameter int DIM = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_data,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         func,
    input  logic [2:0]         row,
    input  logic [2:0]         col,
    input  logic signed [31:0] value,
    input  logic               last,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         index,
    output logic signed [31:0] result_value,
    output logic               end_of_vector,
    output logic               saturated
);

    localparam int AW = $clog2(DIM);

    localparam logic [1:0] ST_RUN    = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_SETTLE = 2'd2;
    localparam logic [1:0] ST_DRAIN  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [2:0]       depth_reg;
    item_t            head_reg;
    item_t            item;
    item_t            link [DIM+1];
    res_t             res_link [DIM+1];
    logic [POS_W-1:0] pos;
    logic             in_acc;
    logic             out_acc;

    assign item_stall   = (state_reg != ST_RUN);
    assign result_valid = (state_reg == ST_DRAIN);
    assign in_acc       = item_valid && !item_stall;
    assign out_acc      = result_valid && !result_stall;

    assign pos = {1'b0, row} + {1'b0, depth_reg};

    always_comb
    begin
        item.valid = in_acc;
        item.op    = OP_SKIP;
        item.tgt   = row;
        item.addr  = {1'b0, row};
        item.value = value;
        item.last  = 1'b0;
        item.point = (func == FUNC_PNT);
        case (func)
            FUNC_MWR:
            begin
                item.tgt = col;
                item.op  = (int'(row) < DIM) ? OP_MWR : OP_SKIP;
            end
            FUNC_OWR:
            begin
                item.op = OP_OWR;
            end
            FUNC_PNT, FUNC_VEC:
            begin
                item.addr = pos;
                item.op   = (int'(pos) < DIM) ? OP_MAC : OP_SKIP;
                item.last = last;
            end
            default:
            begin
                item.op = OP_SKIP;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (in_acc && item.last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (link[DIM].valid && link[DIM].last)
                begin
                    state_next = ST_SETTLE;
                    cnt_next   = SETTLE_CNT;
                end
            end
            ST_SETTLE:
            begin
                if (cnt_reg == 2'd0)
                begin
                    state_next = ST_DRAIN;
                    idx_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg - 2'd1;
                end
            end
            ST_DRAIN:
            begin
                if (out_acc)
                begin
                    idx_next = idx_reg + AW'(1);
                    if (idx_reg == AW'(DIM - 1))
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            depth_reg <= '0;
            head_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            head_reg  <= item;
            if (cfg_write)
            begin
                depth_reg <= cfg_data;
            end
        end
    end

    assign link[0]       = head_reg;
    assign res_link[DIM] = '0;

    for (genvar g = 0; g < DIM; g++)
    begin : g_cell
        apt_cell #(
            .DIM (DIM),
            .IDX (g)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .item_in  (link[g]),
            .item_out (link[g+1]),
            .shift    (out_acc),
            .res_in   (res_link[g+1]),
            .res_out  (res_link[g])
        );
    end

    assign index         = 3'(idx_reg);
    assign result_value  = res_link[0].value;
    assign saturated     = res_link[0].sat;
    assign end_of_vector = (idx_reg == AW'(DIM - 1));

endmodule

// File: design/apt_chk.sv
// apt_chk: port-level assertions for affine_point_transform, with its bind.
// Depends on affine_point_transform's port list only.
module apt_chk
(
    input logic               clk,
    input logic               rst_n,
    input logic               cfg_write,
    input logic [2:0]         cfg_data,
    input logic               item_valid,
    input logic               item_stall,
    input logic [1:0]         func,
    input logic [2:0]         row,
    input logic [2:0]         col,
    input logic signed [31:0] value,
    input logic               last,
    input logic               result_valid,
    input logic               result_stall,
    input logic [2:0]         index,
    input logic signed [31:0] result_value,
    input logic               end_of_vector,
    input logic               saturated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_value)
            && $stable(index))
        else $error("stalled result changed");

    a_no_input_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> item_stall)
        else $error("input open while results pending");

    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && end_of_vector |=> !result_valid)
        else $error("result after end of vector");

    a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_stall && !end_of_vector |=>
            result_valid && index == 3'($past(index) + 3'd1))
        else $error("result index out of sequence");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && saturated |->
            result_value == 32'sh7fff_ffff || result_value == 32'sh8000_0000)
        else $error("saturated transaction without clipped value");

endmodule

bind affine_point_transform apt_chk u_apt_chk (.*);
